>>> design/normal_matrix_inverse_transpose_core_defines.svh
// Assertion macros shared by the normal matrix inverse transpose design.
`ifndef NORMAL_MATRIX_INVERSE_TRANSPOSE_CORE_DEFINES_SVH
`define NORMAL_MATRIX_INVERSE_TRANSPOSE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define NMIT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nmit assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define NMIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nmit assertion failed");

`else

`define NMIT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NMIT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/nmit_pkg.sv
// Shared widths, cofactor tables and types for the normal matrix inverse transpose core.
`default_nettype none
package nmit_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int N_ELEM     = 9;

   // Exact intermediate widths.
   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int COF_W  = PROD_W + 1;
   localparam int LO_W   = 2 * DATA_WIDTH + 2;
   localparam int HI_W   = 2 * DATA_WIDTH + 1;
   localparam int TERM_W = DATA_WIDTH + COF_W;
   localparam int DET_W  = TERM_W + 2;
   localparam int NUM_W  = COF_W + 2 * FRAC_BITS;
   localparam int DEN_W  = DET_W;
   localparam int REM_W  = (NUM_W > DEN_W + DATA_WIDTH) ? NUM_W : DEN_W + DATA_WIDTH;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [3:0] nmit_idx_type;

   // Cofactor k is in[PA_L[k]] * in[PA_R[k]] - in[PB_L[k]] * in[PB_R[k]],
   // with the sign of the odd positions folded into the operand order.
   localparam nmit_idx_type PA_L [N_ELEM] = '{4'd4, 4'd6, 4'd3, 4'd7, 4'd0, 4'd6, 4'd1, 4'd3, 4'd0};
   localparam nmit_idx_type PA_R [N_ELEM] = '{4'd8, 4'd5, 4'd7, 4'd2, 4'd8, 4'd1, 4'd5, 4'd2, 4'd4};
   localparam nmit_idx_type PB_L [N_ELEM] = '{4'd7, 4'd3, 4'd6, 4'd1, 4'd6, 4'd0, 4'd4, 4'd0, 4'd3};
   localparam nmit_idx_type PB_R [N_ELEM] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd2, 4'd7, 4'd2, 4'd5, 4'd1};

   typedef logic signed [DATA_WIDTH-1:0] nmit_data_type;

   typedef struct packed {
      logic [N_ELEM-1:0][COF_W-1:0] cof;
      logic [DET_W-1:0]             det;
   } nmit_entry_type;

   typedef struct packed {
      logic           valid;
      nmit_entry_type entry;
   } nmit_slot_type;

endpackage
`default_nettype wire

>>> design/nmit_front.sv
// Front pipeline: products, cofactors and the determinant of each accepted matrix.
`default_nettype none
module nmit_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire nmit_pkg::nmit_data_type din [nmit_pkg::N_ELEM],
   output nmit_pkg::nmit_slot_type    push
);

   localparam int N  = nmit_pkg::N_ELEM;
   localparam int DW = nmit_pkg::DATA_WIDTH;

   logic                                 a_valid_ff, a_valid_in;
   logic signed [nmit_pkg::PROD_W-1:0]   pa_ff [N], pa_in [N];
   logic signed [nmit_pkg::PROD_W-1:0]   pb_ff [N], pb_in [N];
   nmit_pkg::nmit_data_type              a_row_ff [3], a_row_in [3];

   logic                                 b_valid_ff, b_valid_in;
   logic signed [nmit_pkg::COF_W-1:0]    b_cof_ff [N], b_cof_in [N];
   nmit_pkg::nmit_data_type              b_row_ff [3], b_row_in [3];

   logic                                 c_valid_ff, c_valid_in;
   logic signed [nmit_pkg::LO_W-1:0]     lo_ff [3], lo_in [3];
   logic signed [nmit_pkg::HI_W-1:0]     hi_ff [3], hi_in [3];
   logic signed [nmit_pkg::COF_W-1:0]    c_cof_ff [N], c_cof_in [N];

   logic                                 d_valid_ff, d_valid_in;
   logic signed [nmit_pkg::TERM_W-1:0]   term_ff [3], term_in [3];
   logic signed [nmit_pkg::COF_W-1:0]    d_cof_ff [N], d_cof_in [N];

   logic                                 e_valid_ff, e_valid_in;
   logic signed [nmit_pkg::DET_W-1:0]    det_ff, det_in;
   logic signed [nmit_pkg::COF_W-1:0]    e_cof_ff [N], e_cof_in [N];

   assign a_valid_in = accept;
   assign b_valid_in = a_valid_ff;
   assign c_valid_in = b_valid_ff;
   assign d_valid_in = c_valid_ff;
   assign e_valid_in = d_valid_ff;

   always_comb begin
      logic signed [DW:0] ch;
      for (int k = 0; k < N; k++) begin
         pa_in[k] = din[nmit_pkg::PA_L[k]] * din[nmit_pkg::PA_R[k]];
         pb_in[k] = din[nmit_pkg::PB_L[k]] * din[nmit_pkg::PB_R[k]];
         b_cof_in[k] = nmit_pkg::COF_W'(pa_ff[k]) - nmit_pkg::COF_W'(pb_ff[k]);
         c_cof_in[k] = b_cof_ff[k];
         d_cof_in[k] = c_cof_ff[k];
         e_cof_in[k] = d_cof_ff[k];
      end
      for (int r = 0; r < 3; r++) begin
         a_row_in[r] = din[r];
         b_row_in[r] = a_row_ff[r];
         // Split the cofactor into an unsigned low word and a signed high part.
         ch          = $signed(b_cof_ff[r][nmit_pkg::COF_W-1:DW]);
         lo_in[r]    = b_row_ff[r] * $signed({1'b0, b_cof_ff[r][DW-1:0]});
         hi_in[r]    = b_row_ff[r] * ch;
         term_in[r]  = (nmit_pkg::TERM_W'(hi_ff[r]) <<< DW) + nmit_pkg::TERM_W'(lo_ff[r]);
      end
      det_in = nmit_pkg::DET_W'(term_ff[0]) + nmit_pkg::DET_W'(term_ff[1]) +
               nmit_pkg::DET_W'(term_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      a_row_ff <= a_row_in;
      b_cof_ff <= b_cof_in;
      b_row_ff <= b_row_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      c_cof_ff <= c_cof_in;
      term_ff  <= term_in;
      d_cof_ff <= d_cof_in;
      det_ff   <= det_in;
      e_cof_ff <= e_cof_in;
   end

   always_comb begin
      push.valid     = e_valid_ff;
      push.entry.det = det_ff;
      for (int k = 0; k < N; k++) begin
         push.entry.cof[k] = e_cof_ff[k];
      end
   end

endmodule
`default_nettype wire

>>> design/nmit_queue.sv
// Short queue between the front pipeline and the divider back end.
`default_nettype none
`include "normal_matrix_inverse_transpose_core_defines.svh"
module nmit_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire nmit_pkg::nmit_slot_type push,
   output nmit_pkg::nmit_slot_type      head,
   output logic                         full
);

   localparam int QW = nmit_pkg::QPTR_W;
   localparam int CW = nmit_pkg::QCNT_W;

   nmit_pkg::nmit_entry_type mem_ff [nmit_pkg::QUEUE_DEPTH];
   logic [QW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     head_valid_ff, head_valid_in;
   nmit_pkg::nmit_entry_type head_entry_ff;
   logic                     pop;

   // The back end never stalls, so the head leaves whenever the queue holds one.
   assign pop           = (count_ff != '0);
   assign head_valid_in = pop;
   assign full          = (count_ff == CW'(nmit_pkg::QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QW'(nmit_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(nmit_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push.valid) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         head_valid_ff <= head_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
      head_entry_ff <= mem_ff[rd_ptr_ff];
   end

   assign head.valid = head_valid_ff;
   assign head.entry = head_entry_ff;

   `NMIT_ASSERT_IMPLY(a_queue_level, clock, reset, 1'b1, count_ff <= CW'(1))
   `NMIT_ASSERT_NEXT(a_queue_drain, clock, reset, count_ff != '0, head_valid_ff)

endmodule
`default_nettype wire

>>> design/nmit_div.sv
// One pipelined restoring divider lane, one quotient bit per stage.
`default_nettype none
module nmit_div (
   input  wire logic                       clock,
   input  wire logic [nmit_pkg::NUM_W-1:0] num,
   input  wire logic [nmit_pkg::DEN_W-1:0] den,
   output logic [nmit_pkg::DATA_WIDTH-1:0] quot,
   output logic                            ovf
);

   localparam int DW = nmit_pkg::DATA_WIDTH;
   localparam int RW = nmit_pkg::REM_W;

   logic [RW-1:0]                rem_ff [DW], rem_in [DW];
   logic [nmit_pkg::DEN_W-1:0]   den_ff [DW], den_in [DW];
   logic [DW-1:0]                q_ff [DW+1], q_in [DW+1];
   logic                         ovf_ff [DW+1], ovf_in [DW+1];
   logic [RW-1:0]                trial [DW+1];
   logic                         take [DW+1];

   always_comb begin
      // First stage: a quotient that needs more than DW bits only saturates.
      trial[0]  = RW'(den) << DW;
      take[0]   = RW'(num) >= trial[0];
      rem_in[0] = RW'(num);
      den_in[0] = den;
      q_in[0]   = '0;
      ovf_in[0] = take[0];
      for (int s = 1; s <= DW; s++) begin
         trial[s]  = RW'(den_ff[s-1]) << (DW - s);
         take[s]   = rem_ff[s-1] >= trial[s];
         q_in[s]   = q_ff[s-1];
         ovf_in[s] = ovf_ff[s-1];
         if (take[s]) begin
            q_in[s][DW-s] = 1'b1;
         end
      end
      for (int s = 1; s < DW; s++) begin
         rem_in[s] = take[s] ? rem_ff[s-1] - trial[s] : rem_ff[s-1];
         den_in[s] = den_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign quot = q_ff[DW];
   assign ovf  = ovf_ff[DW];

endmodule
`default_nettype wire

>>> design/nmit_back.sv
// Back end: magnitudes, nine divider lanes, sign, saturation and the singular case.
`default_nettype none
`include "normal_matrix_inverse_transpose_core_defines.svh"
module nmit_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire nmit_pkg::nmit_slot_type head,
   output logic                         rsp_valid,
   output nmit_pkg::nmit_data_type      rsp_data [nmit_pkg::N_ELEM],
   output logic                         rsp_singular
);

   localparam int N  = nmit_pkg::N_ELEM;
   localparam int DW = nmit_pkg::DATA_WIDTH;

   logic                            s0_valid_ff, s0_valid_in;
   logic [nmit_pkg::NUM_W-1:0]      num_ff [N], num_in [N];
   logic [nmit_pkg::DEN_W-1:0]      den_ff, den_in;
   logic [N-1:0]                    s0_neg_ff, s0_neg_in;
   logic                            s0_sing_ff, s0_sing_in;

   logic                            fv_ff [DW+1], fv_in [DW+1];
   logic                            fs_ff [DW+1], fs_in [DW+1];
   logic [N-1:0]                    fn_ff [DW+1], fn_in [DW+1];

   logic [DW-1:0]                   quot [N];
   logic                            ovf [N];

   logic                            out_valid_ff, out_valid_in;
   nmit_pkg::nmit_data_type         res_ff [N], res_in [N];
   logic                            sing_ff, sing_in;

   always_comb begin
      logic                       cneg;
      logic                       dneg;
      logic [nmit_pkg::COF_W-1:0] cmag;
      dneg        = head.entry.det[nmit_pkg::DET_W-1];
      den_in      = dneg ? ~head.entry.det + 1'b1 : head.entry.det;
      s0_sing_in  = (head.entry.det == '0);
      s0_valid_in = head.valid;
      for (int k = 0; k < N; k++) begin
         cneg         = head.entry.cof[k][nmit_pkg::COF_W-1];
         cmag         = cneg ? ~head.entry.cof[k] + 1'b1 : head.entry.cof[k];
         num_in[k]    = nmit_pkg::NUM_W'(cmag) << (2 * nmit_pkg::FRAC_BITS);
         s0_neg_in[k] = cneg ^ dneg;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_lane
      nmit_div u_div (
         .clock (clock),
         .num   (num_ff[k]),
         .den   (den_ff),
         .quot  (quot[k]),
         .ovf   (ovf[k])
      );
   end

   // Side flags travel beside the divider lanes.
   always_comb begin
      fv_in[0] = s0_valid_ff;
      fs_in[0] = s0_sing_ff;
      fn_in[0] = s0_neg_ff;
      for (int i = 1; i <= DW; i++) begin
         fv_in[i] = fv_ff[i-1];
         fs_in[i] = fs_ff[i-1];
         fn_in[i] = fn_ff[i-1];
      end
   end

   always_comb begin
      logic [DW-1:0] lim;
      logic [DW-1:0] mag;
      out_valid_in = fv_ff[DW];
      sing_in      = fs_ff[DW];
      for (int k = 0; k < N; k++) begin
         lim = fn_ff[DW][k] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
         mag = (ovf[k] || (quot[k] > lim)) ? lim : quot[k];
         if (fs_ff[DW]) begin
            res_in[k] = '0;
         end else begin
            res_in[k] = fn_ff[DW][k] ? ~mag + 1'b1 : mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         fv_ff        <= '{default: 1'b0};
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         fv_ff        <= fv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      den_ff     <= den_in;
      s0_neg_ff  <= s0_neg_in;
      s0_sing_ff <= s0_sing_in;
      fs_ff      <= fs_in;
      fn_ff      <= fn_in;
      res_ff     <= res_in;
      sing_ff    <= sing_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_data     = res_ff;
   assign rsp_singular = sing_ff;

   `NMIT_ASSERT_IMPLY(a_back_latency, clock, reset, out_valid_ff, $past(s0_valid_ff, DW + 2))
   `NMIT_ASSERT_IMPLY(a_back_singular, clock, reset, out_valid_ff && sing_ff,
      (res_ff[0] == '0) && (res_ff[N-1] == '0))

endmodule
`default_nettype wire

>>> design/normal_matrix_inverse_transpose_core.sv
// Top level of the normal matrix inverse transpose core.
`default_nettype none
// Usage: the block takes the upper-left 3x3 of a transform as nine signed
// Q16.16 values and returns the inverse transpose, cofactor over determinant,
// each element truncated toward zero and saturated to the Q16.16 range.
// A request is taken at a rising edge where start is high and busy is low.
// Each result is shown for exactly one cycle with rsp_valid high; the
// receiver cannot hold it off. When the determinant is zero, rsp_singular is
// set and all nine elements are zero.
// Throughput is one request per cycle. Between the accepting edge and the edge
// that takes the result, every request passes through the stages below.
// The front pipeline spends five stages on products, cofactors and the
// determinant; the queue spends two, one to store and one to register the head;
// the back spends one stage on magnitudes, then the nine divider lanes spend one
// stage on the overflow test and one stage per quotient bit, and a last stage
// applies sign and saturation. Since the back never stalls, the two-entry queue
// drains each cycle and busy stays low in operation. Reset empties the
// pipelines and the queue.
module normal_matrix_inverse_transpose_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire nmit_pkg::nmit_data_type req_in_r0c0,
   input  wire nmit_pkg::nmit_data_type req_in_r0c1,
   input  wire nmit_pkg::nmit_data_type req_in_r0c2,
   input  wire nmit_pkg::nmit_data_type req_in_r1c0,
   input  wire nmit_pkg::nmit_data_type req_in_r1c1,
   input  wire nmit_pkg::nmit_data_type req_in_r1c2,
   input  wire nmit_pkg::nmit_data_type req_in_r2c0,
   input  wire nmit_pkg::nmit_data_type req_in_r2c1,
   input  wire nmit_pkg::nmit_data_type req_in_r2c2,
   output logic                       rsp_valid,
   output nmit_pkg::nmit_data_type    rsp_out_r0c0,
   output nmit_pkg::nmit_data_type    rsp_out_r0c1,
   output nmit_pkg::nmit_data_type    rsp_out_r0c2,
   output nmit_pkg::nmit_data_type    rsp_out_r1c0,
   output nmit_pkg::nmit_data_type    rsp_out_r1c1,
   output nmit_pkg::nmit_data_type    rsp_out_r1c2,
   output nmit_pkg::nmit_data_type    rsp_out_r2c0,
   output nmit_pkg::nmit_data_type    rsp_out_r2c1,
   output nmit_pkg::nmit_data_type    rsp_out_r2c2,
   output logic                       rsp_singular
);

   nmit_pkg::nmit_data_type din [nmit_pkg::N_ELEM];
   nmit_pkg::nmit_data_type dout [nmit_pkg::N_ELEM];
   nmit_pkg::nmit_slot_type push;
   nmit_pkg::nmit_slot_type head;
   logic                    full;
   logic                    accept;

   // A request enters whenever the queue has room for it.
   assign busy   = full;
   assign accept = start && !full;

   // Row-major order of the matrix elements.
   assign din[0] = req_in_r0c0;
   assign din[1] = req_in_r0c1;
   assign din[2] = req_in_r0c2;
   assign din[3] = req_in_r1c0;
   assign din[4] = req_in_r1c1;
   assign din[5] = req_in_r1c2;
   assign din[6] = req_in_r2c0;
   assign din[7] = req_in_r2c1;
   assign din[8] = req_in_r2c2;

   nmit_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .din    (din),
      .push   (push)
   );

   nmit_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .head  (head),
      .full  (full)
   );

   nmit_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .rsp_valid    (rsp_valid),
      .rsp_data     (dout),
      .rsp_singular (rsp_singular)
   );

   assign rsp_out_r0c0 = dout[0];
   assign rsp_out_r0c1 = dout[1];
   assign rsp_out_r0c2 = dout[2];
   assign rsp_out_r1c0 = dout[3];
   assign rsp_out_r1c1 = dout[4];
   assign rsp_out_r1c2 = dout[5];
   assign rsp_out_r2c0 = dout[6];
   assign rsp_out_r2c1 = dout[7];
   assign rsp_out_r2c2 = dout[8];

endmodule
`default_nettype wire

>>> verif/normal_matrix_inverse_transpose_core_test.sv
// Self-checking testbench for the normal matrix inverse transpose core.
`timescale 1ns / 100ps
`default_nettype none
module normal_matrix_inverse_transpose_core_test;

   localparam int N_RANDOM   = 930;
   localparam int CALM_TAIL  = 150;   // final requests are sent back to back
   localparam int STALL_MAX  = 3000;  // cycles without any handshake
   localparam int DRAIN_WAIT = 60;    // extra wait once every result is in

   localparam logic signed [31:0] ONE  = 32'sh0001_0000;
   localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MINV = 32'sh8000_0000;

   // One expected inverse transpose: nine elements in row order and the flag.
   typedef struct packed {
      logic [8:0][31:0] elem;
      logic             singular;
   } inverse_type;

   // A directed row: the matrix and, where it is obvious, its known answer.
   typedef struct {
      logic signed [31:0] m [9];
      bit                 known;
      inverse_type        answer;
   } matrix_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   nmit_pkg::nmit_data_type req_m [9];
   logic rsp_valid;
   nmit_pkg::nmit_data_type rsp_m [9];
   logic rsp_singular;

   inverse_type pending_inverses [$];
   int  mismatches = 0;
   int  requests_sent = 0;
   int  results_seen = 0;
   int  singular_seen = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;

   always #5 clock = ~clock;

   normal_matrix_inverse_transpose_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_in_r0c0  (req_m[0]),
      .req_in_r0c1  (req_m[1]),
      .req_in_r0c2  (req_m[2]),
      .req_in_r1c0  (req_m[3]),
      .req_in_r1c1  (req_m[4]),
      .req_in_r1c2  (req_m[5]),
      .req_in_r2c0  (req_m[6]),
      .req_in_r2c1  (req_m[7]),
      .req_in_r2c2  (req_m[8]),
      .rsp_valid    (rsp_valid),
      .rsp_out_r0c0 (rsp_m[0]),
      .rsp_out_r0c1 (rsp_m[1]),
      .rsp_out_r0c2 (rsp_m[2]),
      .rsp_out_r1c0 (rsp_m[3]),
      .rsp_out_r1c1 (rsp_m[4]),
      .rsp_out_r1c2 (rsp_m[5]),
      .rsp_out_r2c0 (rsp_m[6]),
      .rsp_out_r2c1 (rsp_m[7]),
      .rsp_out_r2c2 (rsp_m[8]),
      .rsp_singular (rsp_singular)
   );

   // Cofactor over determinant, scaled by 2^(2F) so the quotient lands in
   // Q16.16, truncated toward zero and clamped to the 32-bit signed range.
   function automatic logic [31:0] scaled_quotient(logic signed [127:0] cof,
                                                   logic signed [127:0] det);
      logic         neg;
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] mag;
      logic [127:0] lim;
      neg = cof[127] ^ det[127];
      num = cof[127] ? -cof : cof;
      den = det[127] ? -det : det;
      num = num << (2 * nmit_pkg::FRAC_BITS);
      mag = num / den;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (mag > lim)
         mag = lim;
      if (neg)
         mag = -mag;
      return mag[31:0];
   endfunction

   // Exact cofactors and determinant in 128-bit signed arithmetic.
   function automatic inverse_type inverse_transpose(logic signed [31:0] m [9]);
      logic signed [127:0] a [9];
      logic signed [127:0] cof [9];
      logic signed [127:0] det;
      inverse_type r;
      for (int i = 0; i < 9; i++)
         a[i] = m[i];
      cof[0] =   a[4] * a[8] - a[7] * a[5];
      cof[1] = -(a[3] * a[8] - a[6] * a[5]);
      cof[2] =   a[3] * a[7] - a[6] * a[4];
      cof[3] = -(a[1] * a[8] - a[7] * a[2]);
      cof[4] =   a[0] * a[8] - a[6] * a[2];
      cof[5] = -(a[0] * a[7] - a[6] * a[1]);
      cof[6] =   a[1] * a[5] - a[4] * a[2];
      cof[7] = -(a[0] * a[5] - a[3] * a[2]);
      cof[8] =   a[0] * a[4] - a[3] * a[1];
      det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
      r = '0;
      if (det == 0) begin
         r.singular = 1'b1;
      end else begin
         for (int i = 0; i < 9; i++)
            r.elem[i] = scaled_quotient(cof[i], det);
      end
      return r;
   endfunction

   // Present one request and hold it until the core takes it. The caller
   // decides afterwards whether start drops for an idle gap.
   task automatic send_matrix(logic signed [31:0] m [9], bit known, inverse_type answer);
      start <= 1'b1;
      for (int i = 0; i < 9; i++)
         req_m[i] <= m[i];
      do
         @(posedge clock);
      while (busy);
      pending_inverses.push_back(known ? answer : inverse_transpose(m));
      requests_sent++;
   endtask

   task automatic maybe_idle();
      if (!calm && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] pick_value(int mode);
      case (mode)
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 5))
               0: return MAXV;
               1: return MINV;
               2: return 32'sd0;
               3: return 32'sd1;
               4: return -32'sd1;
               default: return $urandom;
            endcase
         end
         default: return $signed($urandom_range(0, 8 * 65536)) - 32'sd262144;
      endcase
   endfunction

   // Directed cases: identity and scaled identities, the zero matrix and other
   // singular shapes, saturation both ways, and the extremes of every field.
   task automatic run_directed();
      matrix_case_type t [$];
      matrix_case_type c;
      inverse_type zero_out;
      zero_out = '0;

      c.m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};   // identity maps to itself
      c.known = 1'b1;
      c.answer = '0;
      c.answer.elem[0] = ONE; c.answer.elem[4] = ONE; c.answer.elem[8] = ONE;
      t.push_back(c);

      c.m = '{2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE};  // inverse is one half
      c.answer = '0;
      c.answer.elem[0] = 32'h8000; c.answer.elem[4] = 32'h8000; c.answer.elem[8] = 32'h8000;
      t.push_back(c);

      c.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};          // zero matrix is singular
      c.answer = zero_out; c.answer.singular = 1'b1;
      t.push_back(c);

      c.m = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV};  // rank one
      t.push_back(c);
      c.m = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV};
      t.push_back(c);
      c.m = '{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 5, 7, 9};  // equal rows
      t.push_back(c);

      // The smallest step on the diagonal overflows the positive range.
      c.m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      c.answer = '0;
      c.answer.elem[0] = 32'h7FFF_FFFF; c.answer.elem[4] = 32'h7FFF_FFFF;
      c.answer.elem[8] = 32'h7FFF_FFFF;
      t.push_back(c);

      // Same with a negative determinant: clamps to the most negative value.
      c.m = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};
      c.answer = '0;
      c.answer.elem[0] = 32'h8000_0000; c.answer.elem[4] = 32'h8000_0000;
      c.answer.elem[8] = 32'h8000_0000;
      t.push_back(c);

      // The remaining rows are checked against the predictor.
      c.known = 1'b0;
      c.m = '{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV}; t.push_back(c);
      c.m = '{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV}; t.push_back(c);
      c.m = '{MAXV, MINV, 0, MINV, MAXV, 0, 0, 0, MINV}; t.push_back(c);
      c.m = '{0, ONE, 0, ONE, 0, 0, 0, 0, -ONE}; t.push_back(c);
      c.m = '{3 * ONE, 1, -7, 5, -2 * ONE, 9, -1, 4, ONE / 2}; t.push_back(c);
      c.m = '{-1, -1, -1, -1, 32'sh7FFF_0000, 1, 1, 0, 32'sh8000_FFFF}; t.push_back(c);
      c.m = '{ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE}; t.push_back(c);
      c.m = '{32'sh5555_5555, 32'shAAAA_AAAA, 1, 32'shAAAA_AAAA, 32'sh5555_5555, 2,
              3, 4, 32'sh0F0F_0F0F}; t.push_back(c);

      foreach (t[i]) begin
         send_matrix(t[i].m, t[i].known, t[i].answer);
         maybe_idle();
      end
   endtask

   // Random requests: full-range words, small values, extremes, and
   // deliberately singular matrices with a repeated row or a zero column.
   task automatic run_random();
      logic signed [31:0] m [9];
      inverse_type none;
      int mode;
      none = '0;
      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= N_RANDOM - CALM_TAIL);
         mode = $urandom_range(0, 2);
         for (int i = 0; i < 9; i++)
            m[i] = pick_value(mode);
         case ($urandom_range(0, 9))
            0: for (int i = 0; i < 3; i++) m[6 + i] = m[i];
            1: begin
               m[1] = 0; m[4] = 0; m[7] = 0;
            end
            default: ;
         endcase
         send_matrix(m, 1'b0, none);
         // Let the pipeline drain completely once before carrying on.
         if (n == N_RANDOM / 2) begin
            start <= 1'b0;
            while (pending_inverses.size() != 0)
               @(posedge clock);
         end else begin
            maybe_idle();
         end
      end
      start <= 1'b0;
   endtask

   // Compare every result against the oldest outstanding expectation.
   always @(posedge clock) begin
      inverse_type want;
      inverse_type got;
      if (!reset && rsp_valid) begin
         results_seen++;
         for (int i = 0; i < 9; i++)
            got.elem[i] = rsp_m[i];
         got.singular = rsp_singular;
         if (got.singular)
            singular_seen++;
         if (pending_inverses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected result, nothing outstanding", $realtime);
         end else begin
            want = pending_inverses.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("[%0t] result mismatch on result %0d", $realtime, results_seen);
                  for (int i = 0; i < 9; i++)
                     if (got.elem[i] != want.elem[i])
                        $display("   element %0d expected %h got %h",
                                 i, want.elem[i], got.elem[i]);
                  if (got.singular != want.singular)
                     $display("   singular expected %b got %b",
                              want.singular, got.singular);
               end
            end
         end
      end
   end

   // Watchdog: any cycle with a handshake on either side resets the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_MAX) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < 9; i++)
         req_m[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      while (pending_inverses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d matrices (directed and random, with idle bursts and a full drain);",
               requests_sent);
      $display("checked %0d results, %0d singular, %0d mismatches.",
               results_seen, singular_seen, mismatches);
      if (mismatches == 0 && pending_inverses.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
